@@ sv/clsm_pkg.sv @@
// Package for the CAN signal layout mask unit.
// Holds the frame size, the word types of both channels and the sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps

package clsm_pkg;

    // Number of usable bit positions in one frame (8 to 64).
    localparam int FRAME_BITS = 64;

    // Width of the coverage mask; it is always the full CAN payload.
    localparam int MASK_W = 64;

    // A walk position is byte index (up to 8) times eight plus a bit index.
    localparam int BYTE_W = 4;
    localparam int BIT_W  = 3;
    localparam int POS_W  = BYTE_W + BIT_W;

    // Widths of the item fields.
    localparam int ID_W  = 29;
    localparam int LEN_W = 7;

    // Byte order codes.
    localparam logic ORDER_MOTOROLA = 1'b0;
    localparam logic ORDER_INTEL    = 1'b1;

    // One signal descriptor.
    typedef struct packed {
        logic [ID_W-1:0]  message_id;
        logic             signal_valid;
        logic [5:0]       start_bit;
        logic [LEN_W-1:0] signal_length;
        logic             byte_order;
        logic             last_signal;
    } sig_word_t;

    // One finished message.
    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic [MASK_W-1:0] coverage_mask;
        logic              out_of_frame;
    } res_word_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

@@ sv/can_signal_layout_mask_unit.sv @@
// Top level of the CAN signal layout mask unit.
// Walks each signal bit by bit in a shared position stepper; uses clsm_pkg.
`timescale 1ns / 1ps

// The unit takes one signal descriptor per word and walks its bits one per cycle
// through a single position stepper, XORing each covered position into a mask
// that starts as all ones. A valid descriptor of nonzero length is walked for
// signal_length bits after it is accepted, cut short once the walk reaches a
// byte that lies wholly past the frame, which raises out_of_frame.
// Positions past the frame inside a partly used last byte are flagged, not XORed.
// A word marked last_signal then enters the finish step to move the message id
// and mask into the output register, waiting while that register still holds a
// result that waits to be taken. sig_stall stays high while a walk or the finish
// step is in progress; the output register lets the next descriptor be accepted
// while a finished result still waits to be taken.
module can_signal_layout_mask_unit
    import clsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sig_valid,
    output logic      sig_stall,
    input  sig_word_t sig_word,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res_word
);

    state_t            state_reg, state_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              overflow_reg, overflow_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              order_reg, order_next;
    logic              last_reg, last_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic              res_valid_reg, res_valid_next;
    res_word_t         res_word_reg, res_word_next;

    logic              sig_accept;
    logic              res_free;
    logic [POS_W-1:0]  pos;
    logic              pos_in_frame;
    logic              byte_in_frame;

    assign sig_stall  = (state_reg != ST_IDLE);
    assign sig_accept = sig_valid && !sig_stall;
    assign res_free   = !res_valid_reg || !res_stall;
    assign res_valid  = res_valid_reg;
    assign res_word   = res_word_reg;

    // Current walk position and whether it, or any bit of its byte, lands in the frame.
    assign pos           = {byte_reg, bit_reg};
    assign pos_in_frame  = (pos < POS_W'(FRAME_BITS));
    assign byte_in_frame = ({byte_reg, 3'b000} < POS_W'(FRAME_BITS));

    // Sequencer and shared position stepper.
    always_comb
    begin
        state_next     = state_reg;
        mask_next      = mask_reg;
        overflow_next  = overflow_reg;
        byte_next      = byte_reg;
        bit_next       = bit_reg;
        count_next     = count_reg;
        order_next     = order_reg;
        last_next      = last_reg;
        id_next        = id_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_word_next  = res_word_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sig_accept)
                begin
                    byte_next  = {1'b0, sig_word.start_bit[5:3]};
                    bit_next   = sig_word.start_bit[2:0];
                    count_next = sig_word.signal_length;
                    order_next = sig_word.byte_order;
                    last_next  = sig_word.last_signal;
                    id_next    = sig_word.message_id;
                    if (sig_word.signal_valid && (sig_word.signal_length != '0))
                        state_next = ST_WALK;
                    else if (sig_word.last_signal)
                        state_next = ST_FINISH;
                end
            end
            ST_WALK:
            begin
                if (byte_in_frame)
                begin
                    if (pos_in_frame)
                        mask_next = mask_reg ^ (MASK_W'(1) << pos[5:0]);
                    else
                        overflow_next = 1'b1;
                    count_next = count_reg - LEN_W'(1);
                    // Step to the next bit in the chosen byte order.
                    if (order_reg == ORDER_INTEL)
                    begin
                        if (bit_reg == BIT_W'(7))
                        begin
                            bit_next  = '0;
                            byte_next = byte_reg + BYTE_W'(1);
                        end
                        else
                            bit_next = bit_reg + BIT_W'(1);
                    end
                    else
                    begin
                        if (bit_reg == '0)
                        begin
                            bit_next  = BIT_W'(7);
                            byte_next = byte_reg + BYTE_W'(1);
                        end
                        else
                            bit_next = bit_reg - BIT_W'(1);
                    end
                    if (count_reg == LEN_W'(1))
                        state_next = last_reg ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    // Walk only moves forward by bytes, so the rest is out of frame too.
                    overflow_next = 1'b1;
                    state_next    = last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (res_free)
                begin
                    res_valid_next              = 1'b1;
                    res_word_next.result_id     = id_reg;
                    res_word_next.coverage_mask = mask_reg;
                    res_word_next.out_of_frame  = overflow_reg;
                    mask_next                   = '1;
                    overflow_next               = 1'b0;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '1;
            overflow_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            overflow_reg  <= overflow_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        bit_reg      <= bit_next;
        count_reg    <= count_next;
        order_reg    <= order_next;
        last_reg     <= last_next;
        id_reg       <= id_next;
        res_word_reg <= res_word_next;
    end

    // A new result only appears out of the finish step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    // A walk never runs with nothing left to cover.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (count_reg != '0))
        else $error("walk step with zero remaining length");

    // A nonempty signal always starts a walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sig_accept && sig_word.signal_valid && (sig_word.signal_length != '0))
        |=> (state_reg == ST_WALK))
        else $error("signal accepted without a walk");

    // Handing off a result returns the mask and flag to their start values.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && res_free) |=> (mask_reg == '1 && !overflow_reg))
        else $error("mask not restored after a result");

endmodule
